// ===== rtl/ksm_pkg.sv =====
// ----------------------------------------------------------------------------
// ksm_pkg
// Shared types and constants of the scalar Kalman smoother: default widths,
// register indexes, sequencer states and operations of the iterative unit.
// ----------------------------------------------------------------------------
package ksm_pkg;

  localparam int unsigned FRAC_BITS_DEF    = 24;
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned OUT_W            = 16;
  localparam int unsigned COV_W            = 32;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned CFG_DATA_W       = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_SETUP,
    ST_DIV,
    ST_MLOAD,
    ST_MUL,
    ST_UPD,
    ST_OUT
  } ksm_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DIV_LOAD,
    OP_GAIN_ZERO,
    OP_GAIN_ONE,
    OP_DIV_STEP,
    OP_MUL_LOAD,
    OP_MUL_STEP
  } ksm_op_e;

endpackage

// ===== rtl/ksm_alu.sv =====
// ----------------------------------------------------------------------------
// ksm_alu
// Iterative arithmetic unit: restoring gain division one quotient bit per
// cycle, then two shift-add multiplications one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ksm_alu #(
  parameter int unsigned FRAC_BITS = ksm_pkg::FRAC_BITS_DEF,
  parameter int unsigned MAG_W     = ksm_pkg::SAMPLE_WIDTH_DEF + ksm_pkg::FRAC_BITS_DEF + 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ksm_pkg::ksm_op_e          op_i,
  input  logic [ksm_pkg::COV_W-1:0] pred_i,
  input  logic [ksm_pkg::COV_W:0]   denom_i,
  input  logic [MAG_W-1:0]          mag_i,
  output logic                      last_o,
  output logic [MAG_W-1:0]          step_mag_o,
  output logic [ksm_pkg::COV_W-1:0] cov_o
);
  import ksm_pkg::*;

  localparam int unsigned AW    = ((MAG_W > COV_W + 2) ? MAG_W : COV_W + 2) + 1;
  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 2);
  localparam logic [FRAC_BITS:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

  logic [COV_W:0]     rem_q;
  logic [FRAC_BITS:0] gain_q;
  logic [FRAC_BITS:0] mq_q;
  logic [FRAC_BITS:0] mb_q;
  logic [MAG_W-1:0]   acc_a_q;
  logic [COV_W-1:0]   acc_b_q;
  logic [CNT_W-1:0]   cnt_q;

  logic          div_mode;
  logic [AW-1:0] add_a;
  logic [AW-1:0] add_b;
  logic [AW-1:0] add_s;
  logic          div_ge;
  logic [COV_W:0] sum_b;

  assign div_mode = (op_i == OP_DIV_STEP);
  assign add_a    = div_mode ? AW'({rem_q, 1'b0}) : AW'(acc_a_q);
  assign add_b    = div_mode ? AW'(denom_i) : (mq_q[0] ? AW'(mag_i) : '0);
  assign add_s    = add_a + (div_mode ? ~add_b : add_b) + AW'(div_mode);
  assign div_ge   = ~add_s[AW-1];
  assign sum_b    = {1'b0, acc_b_q} + (mb_q[0] ? {1'b0, pred_i} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      unique case (op_i)
        OP_DIV_LOAD: cnt_q <= CNT_W'(FRAC_BITS);
        OP_MUL_LOAD: cnt_q <= CNT_W'(FRAC_BITS + 1);
        OP_DIV_STEP,
        OP_MUL_STEP: cnt_q <= cnt_q - CNT_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_DIV_LOAD: begin
        rem_q  <= {1'b0, pred_i};
        gain_q <= '0;
      end
      OP_GAIN_ZERO: gain_q <= '0;
      OP_GAIN_ONE:  gain_q <= ONE_FX;
      OP_DIV_STEP: begin
        rem_q  <= div_ge ? add_s[COV_W:0] : {rem_q[COV_W-1:0], 1'b0};
        gain_q <= {gain_q[FRAC_BITS-1:0], div_ge};
      end
      OP_MUL_LOAD: begin
        mq_q    <= gain_q;
        mb_q    <= ONE_FX - gain_q;
        acc_a_q <= '0;
        acc_b_q <= '0;
      end
      OP_MUL_STEP: begin
        acc_a_q <= add_s[MAG_W:1];
        mq_q    <= {add_s[0], mq_q[FRAC_BITS:1]};
        acc_b_q <= sum_b[COV_W:1];
        mb_q    <= {sum_b[0], mb_q[FRAC_BITS:1]};
      end
      default: ;
    endcase
  end

  assign last_o     = (cnt_q == CNT_W'(1));
  assign step_mag_o = {acc_a_q[MAG_W-2:0], mq_q[FRAC_BITS]};
  assign cov_o      = {acc_b_q[COV_W-2:0], mb_q[FRAC_BITS]};

endmodule

// ===== rtl/scalar_kalman_smoother_top.sv =====
// ----------------------------------------------------------------------------
// Operation: a new sample is accepted only in the idle state, once the previous
// result has been loaded into the output register. Each sample passes through the
// bit-serial divider and then the bit-serial multipliers; the divider is skipped
// when the gain is trivially zero or one.
// Reset: estimate clears to zero, covariance and noise registers take their
// default values; no clearing pass.
// ----------------------------------------------------------------------------
// scalar_kalman_smoother_top
// One-dimensional Kalman filter over signed encoder samples, fixed point.
// ----------------------------------------------------------------------------
module scalar_kalman_smoother_top #(
  parameter int unsigned FRAC_BITS    = ksm_pkg::FRAC_BITS_DEF,
  parameter int unsigned SAMPLE_WIDTH = ksm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [ksm_pkg::OUT_W-1:0]   filtered_o,
  input  logic                               cfg_we_i,
  input  logic [ksm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ksm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import ksm_pkg::*;

  localparam int unsigned EST_W = SAMPLE_WIDTH + FRAC_BITS + 1;
  localparam int unsigned MAG_W = EST_W + 1;
  localparam int unsigned IPW   = SAMPLE_WIDTH + 1;
  localparam int unsigned CW    = ((IPW > OUT_W) ? IPW : OUT_W) + 1;

  localparam logic [63:0] ONE_FX = 64'd1 << FRAC_BITS;
  localparam logic [COV_W-1:0] COV_RST = COV_W'((2 * ONE_FX + 50) / 100);
  localparam logic [COV_W-1:0] PN_RST  = COV_W'((ONE_FX + 500) / 1000);
  localparam logic [COV_W-1:0] MN_RST  = COV_W'((543 * ONE_FX + 500) / 1000);

  localparam logic signed [MAG_W:0] EST_HI = {3'b000, {(EST_W-1){1'b1}}};
  localparam logic signed [MAG_W:0] EST_LO = {3'b111, {(EST_W-1){1'b0}}};
  localparam logic signed [CW-1:0]  OUT_HI = {{(CW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [CW-1:0]  OUT_LO = {{(CW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  ksm_state_e state_q, state_d;
  ksm_op_e    alu_op;

  logic [COV_W-1:0]               pn_q;
  logic [COV_W-1:0]               mn_q;
  logic signed [EST_W-1:0]        est_q, est_d;
  logic [COV_W-1:0]               cov_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic [COV_W-1:0]               pred_q;
  logic [COV_W:0]                 denom_q;
  logic signed [MAG_W-1:0]        diff_q;
  logic [MAG_W-1:0]               mag_q;
  logic                           neg_q;
  logic                           out_valid_q;
  logic signed [OUT_W-1:0]        filtered_q, filtered_d;

  logic                                   in_xfer;
  logic                                   out_free;
  logic [COV_W:0]                         pred_sum;
  logic [COV_W-1:0]                       pred_d;
  logic signed [SAMPLE_WIDTH+FRAC_BITS-1:0] samp_fx;
  logic signed [MAG_W-1:0]                diff_d;
  logic [MAG_W-1:0]                       mag_d;
  logic                                   gain_zero;
  logic                                   gain_one;
  logic                                   alu_last;
  logic [MAG_W-1:0]                       step_mag;
  logic [COV_W-1:0]                       cov_new;
  logic signed [MAG_W:0]                  est_x;
  logic signed [MAG_W:0]                  step_x;
  logic signed [MAG_W:0]                  ne_w;
  logic signed [EST_W-1:0]                bias;
  logic signed [EST_W-1:0]                trunc;
  logic signed [IPW-1:0]                  ip;
  logic signed [CW-1:0]                   ip_c;

  ksm_alu #(
    .FRAC_BITS (FRAC_BITS),
    .MAG_W     (MAG_W)
  ) u_alu (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (alu_op),
    .pred_i     (pred_q),
    .denom_i    (denom_q),
    .mag_i      (mag_q),
    .last_o     (alu_last),
    .step_mag_o (step_mag),
    .cov_o      (cov_new)
  );

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  assign pred_sum = {1'b0, cov_q} + {1'b0, pn_q};
  assign pred_d   = pred_sum[COV_W] ? '1 : pred_sum[COV_W-1:0];
  assign samp_fx  = {sample_q, {FRAC_BITS{1'b0}}};
  assign diff_d   = MAG_W'(samp_fx) - MAG_W'(est_q);
  assign mag_d    = diff_q[MAG_W-1] ? MAG_W'(~diff_q) + MAG_W'(1) : diff_q;

  assign gain_zero = (pred_q == '0) && (mn_q == '0);
  assign gain_one  = (mn_q == '0) && (pred_q != '0);

  assign est_x  = (MAG_W+1)'(est_q);
  assign step_x = signed'({1'b0, step_mag});
  assign ne_w   = neg_q ? est_x - step_x : est_x + step_x;

  always_comb begin
    if (ne_w > EST_HI) begin
      est_d = EST_HI[EST_W-1:0];
    end else if (ne_w < EST_LO) begin
      est_d = EST_LO[EST_W-1:0];
    end else begin
      est_d = ne_w[EST_W-1:0];
    end
  end

  assign bias  = {{(EST_W-FRAC_BITS){1'b0}}, {FRAC_BITS{est_q[EST_W-1]}}};
  assign trunc = est_q + bias;
  assign ip    = trunc[EST_W-1:FRAC_BITS];
  assign ip_c  = CW'(ip);

  always_comb begin
    if (ip_c > OUT_HI) begin
      filtered_d = OUT_HI[OUT_W-1:0];
    end else if (ip_c < OUT_LO) begin
      filtered_d = OUT_LO[OUT_W-1:0];
    end else begin
      filtered_d = ip_c[OUT_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_PRED;
      ST_PRED:  state_d = ST_SETUP;
      ST_SETUP: state_d = (gain_zero || gain_one) ? ST_MLOAD : ST_DIV;
      ST_DIV:   if (alu_last) state_d = ST_MLOAD;
      ST_MLOAD: state_d = ST_MUL;
      ST_MUL:   if (alu_last) state_d = ST_UPD;
      ST_UPD:   state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    alu_op     = OP_NONE;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_SETUP: begin
        priority if (gain_zero) begin
          alu_op = OP_GAIN_ZERO;
        end else if (gain_one) begin
          alu_op = OP_GAIN_ONE;
        end else begin
          alu_op = OP_DIV_LOAD;
        end
      end
      ST_DIV:   alu_op = OP_DIV_STEP;
      ST_MLOAD: alu_op = OP_MUL_LOAD;
      ST_MUL:   alu_op = OP_MUL_STEP;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pn_q        <= PN_RST;
      mn_q        <= MN_RST;
      est_q       <= '0;
      cov_q       <= COV_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PROC_NOISE: pn_q <= cfg_wdata_i[COV_W-1:0];
          REG_MEAS_NOISE: mn_q <= cfg_wdata_i[COV_W-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_UPD) begin
        est_q <= est_d;
        cov_q <= cov_new;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sample_q <= sample_i;
    end
    if (state_q == ST_PRED) begin
      pred_q <= pred_d;
      diff_q <= diff_d;
    end
    if (state_q == ST_SETUP) begin
      denom_q <= {1'b0, pred_q} + {1'b0, mn_q};
      mag_q   <= mag_d;
      neg_q   <= diff_q[MAG_W-1];
    end
    if (state_q == ST_OUT && out_free) begin
      filtered_q <= filtered_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;

endmodule

// ===== dv/tb_scalar_kalman_smoother_top.sv =====
// ----------------------------------------------------------------------------
// tb_scalar_kalman_smoother_top
// Self-checking bench for the scalar Kalman smoother. A short table of
// directed samples and register writes covers reset state, full-scale
// inputs, unity and zero gain, the zero-divisor case and writes to unused
// indexes. Random phases follow, each with its own noise settings and a mix
// of encoder-like walks, full-range values and extremes. Every filtered
// transfer is checked against its table value or a fixed-point filter model.
// ----------------------------------------------------------------------------
module tb_scalar_kalman_smoother_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ksm_pkg::*;

  localparam int unsigned FRAC        = FRAC_BITS_DEF;
  localparam int unsigned SW          = SAMPLE_WIDTH_DEF;
  localparam int unsigned EW          = SW + FRAC + 1;
  localparam longint      ONE         = longint'(1) << FRAC;
  localparam longint      EST_MAX     = (longint'(1) << (EW - 1)) - 1;
  localparam longint      EST_MIN     = -EST_MAX - 1;
  localparam longint      OUT_MAX     = 32767;
  localparam longint      OUT_MIN     = -32768;
  localparam int          LATENCY     = 2 * FRAC + 6;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          NPHASE      = 8;
  localparam int          PHASE_ITEMS = 235;
  localparam int          NROWS       = 26;

  localparam logic [CFG_IDX_W-1:0]  REG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0]  REG_SPARE3 = 2'd3;
  localparam logic [CFG_DATA_W-1:0] PN_RESET   = 32'd16777;
  localparam logic [CFG_DATA_W-1:0] MN_RESET   = 32'd9110028;
  localparam logic [COV_W-1:0]      COV_RESET  = 32'd335544;
  localparam logic [CFG_DATA_W-1:0] NOISE_MAX  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_CHECKED,
    ROW_WRITE
  } row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic signed [SW-1:0]   smp;
    logic signed [OUT_W-1:0] fexp;
  } stim_row_t;

  logic                        clk_i;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready_o;
  logic signed [SW-1:0]        smp_q;
  logic                        out_valid_o;
  logic                        out_ready;
  logic signed [OUT_W-1:0]     filtered_o;
  logic                        cfg_we;
  logic [CFG_IDX_W-1:0]        cfg_idx;
  logic [CFG_DATA_W-1:0]       cfg_wdata;

  logic                        chk_q;
  logic signed [OUT_W-1:0]     chk_val_q;

  logic signed [EW-1:0]        est_q;
  logic [COV_W-1:0]            cov_q;
  logic [CFG_DATA_W-1:0]       pnoise_q;
  logic [CFG_DATA_W-1:0]       mnoise_q;
  logic signed [OUT_W-1:0]     filtered_q[$];

  int mismatches;
  int samples_sent;
  int results_seen;
  int gain_zero_cnt;
  int gain_one_cnt;
  int settings_cnt;
  int idle_pct;
  int stall_left;
  int walk_pos;

  stim_row_t stim_rows [0:NROWS-1] = '{
    '{ROW_CHECKED, REG_PROC_NOISE, 32'd0, 16'sd0, 16'sd0},
    '{ROW_PREDICT, REG_PROC_NOISE, 32'd0, 16'sd100, 16'sd0},
    '{ROW_PREDICT, REG_PROC_NOISE, 32'd0, -16'sd100, 16'sd0},
    '{ROW_WRITE, REG_MEAS_NOISE, 32'd0, 16'sd0, 16'sd0},
    '{ROW_CHECKED, REG_PROC_NOISE, 32'd0, 16'sd32767, 16'sd32767},
    '{ROW_CHECKED, REG_PROC_NOISE, 32'd0, 16'sh8000, 16'sh8000},
    '{ROW_CHECKED, REG_PROC_NOISE, 32'd0, -16'sd1, -16'sd1},
    '{ROW_WRITE, REG_PROC_NOISE, 32'd0, 16'sd0, 16'sd0},
    '{ROW_CHECKED, REG_PROC_NOISE, 32'd0, 16'sd32767, -16'sd1},
    '{ROW_CHECKED, REG_PROC_NOISE, 32'd0, 16'sh8000, -16'sd1},
    '{ROW_WRITE, REG_SPARE2, 32'h1234_5678, 16'sd0, 16'sd0},
    '{ROW_WRITE, REG_SPARE3, NOISE_MAX, 16'sd0, 16'sd0},
    '{ROW_CHECKED, REG_PROC_NOISE, 32'd0, 16'sd5, -16'sd1},
    '{ROW_WRITE, REG_PROC_NOISE, NOISE_MAX, 16'sd0, 16'sd0},
    '{ROW_WRITE, REG_MEAS_NOISE, NOISE_MAX, 16'sd0, 16'sd0},
    '{ROW_CHECKED, REG_PROC_NOISE, 32'd0, 16'sh8000, -16'sd16384},
    '{ROW_PREDICT, REG_PROC_NOISE, 32'd0, 16'sd32767, 16'sd0},
    '{ROW_WRITE, REG_MEAS_NOISE, 32'd1, 16'sd0, 16'sd0},
    '{ROW_PREDICT, REG_PROC_NOISE, 32'd0, 16'sd32767, 16'sd0},
    '{ROW_PREDICT, REG_PROC_NOISE, 32'd0, 16'sh8000, 16'sd0},
    '{ROW_WRITE, REG_PROC_NOISE, 32'd1, 16'sd0, 16'sd0},
    '{ROW_PREDICT, REG_PROC_NOISE, 32'd0, 16'sd1234, 16'sd0},
    '{ROW_WRITE, REG_PROC_NOISE, PN_RESET, 16'sd0, 16'sd0},
    '{ROW_WRITE, REG_MEAS_NOISE, MN_RESET, 16'sd0, 16'sd0},
    '{ROW_PREDICT, REG_PROC_NOISE, 32'd0, 16'sh5555, 16'sd0},
    '{ROW_PREDICT, REG_PROC_NOISE, 32'd0, 16'shAAAA, 16'sd0}
  };

  scalar_kalman_smoother_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .sample_i    (smp_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .filtered_o  (filtered_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic signed [OUT_W-1:0] smooth_step(input logic signed [SW-1:0] s);
    logic [63:0]  pred;
    logic [63:0]  denom;
    logic [63:0]  gain;
    logic [63:0]  mag;
    logic [63:0]  stepmag;
    logic [127:0] prod;
    longint       diff;
    longint       nxt;
    longint       ipart;
    pred = 64'(cov_q) + 64'(pnoise_q);
    if (pred > 64'hFFFF_FFFF) pred = 64'hFFFF_FFFF;
    denom = pred + 64'(mnoise_q);
    gain  = (denom == 64'd0) ? 64'd0 : (pred << FRAC) / denom;
    if (gain > 64'(ONE)) gain = 64'(ONE);
    if (gain == 64'd0) gain_zero_cnt++;
    if (gain == 64'(ONE)) gain_one_cnt++;
    diff    = longint'(s) * ONE - longint'(est_q);
    mag     = (diff < 0) ? 64'(-diff) : 64'(diff);
    prod    = 128'(mag) * 128'(gain);
    stepmag = 64'(prod >> FRAC);
    if (stepmag > mag) stepmag = mag;
    nxt = (diff < 0) ? longint'(est_q) - longint'(stepmag)
                     : longint'(est_q) + longint'(stepmag);
    if (nxt > EST_MAX) nxt = EST_MAX;
    if (nxt < EST_MIN) nxt = EST_MIN;
    est_q = nxt[EW-1:0];
    cov_q = 32'(((64'(ONE) - gain) * pred) >> FRAC);
    ipart = (nxt >= 0) ? (nxt >>> FRAC) : -((-nxt) >>> FRAC);
    if (ipart > OUT_MAX) ipart = OUT_MAX;
    if (ipart < OUT_MIN) ipart = OUT_MIN;
    return ipart[OUT_W-1:0];
  endfunction

  function automatic logic signed [SW-1:0] next_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      walk_pos = walk_pos + int'($urandom_range(0, 64)) - 32;
      if (walk_pos > 32767) walk_pos = 32767;
      if (walk_pos < -32768) walk_pos = -32768;
    end else if (r < 90) begin
      walk_pos = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      case ($urandom_range(0, 3))
        0: walk_pos = 32767;
        1: walk_pos = -32768;
        2: walk_pos = 0;
        default: walk_pos = -1;
      endcase
    end
    return walk_pos[SW-1:0];
  endfunction

  task automatic send_sample(input logic signed [SW-1:0] s, input logic checked,
                             input logic signed [OUT_W-1:0] fexp);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    smp_q     <= s;
    chk_q     <= checked;
    chk_val_q <= fexp;
    do @(posedge clk_i); while (!in_ready_o);
    samples_sent++;
  endtask

  task automatic drain_filter();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (filtered_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (rst_n && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(1, 6);
    end
    out_ready <= rst_n && (stall_left == 0);
  end

  always @(posedge clk_i) begin
    logic signed [OUT_W-1:0] predicted;
    logic signed [OUT_W-1:0] want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_PROC_NOISE: pnoise_q = cfg_wdata;
          REG_MEAS_NOISE: mnoise_q = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready_o) begin
        predicted = smooth_step(smp_q);
        filtered_q.push_back(chk_q ? chk_val_q : predicted);
      end
      if (out_valid_o && out_ready) begin
        results_seen++;
        if (filtered_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected filtered transfer: %0d", filtered_o);
        end else begin
          want = filtered_q.pop_front();
          if (filtered_o !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("filtered mismatch: expected %0d got %0d", want, filtered_o);
            end
          end
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout: %0d results still pending", filtered_q.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] pn;
    logic [CFG_DATA_W-1:0] mn;
    mismatches    = 0;
    samples_sent  = 0;
    results_seen  = 0;
    gain_zero_cnt = 0;
    gain_one_cnt  = 0;
    settings_cnt  = 0;
    idle_pct      = 0;
    stall_left    = 0;
    walk_pos      = 0;
    est_q         = '0;
    cov_q         = COV_RESET;
    pnoise_q      = PN_RESET;
    mnoise_q      = MN_RESET;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    smp_q     <= '0;
    chk_q     <= 1'b0;
    chk_val_q <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= REG_PROC_NOISE;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    idle_pct = 20;
    for (int i = 0; i < NROWS; i++) begin
      if (stim_rows[i].kind == ROW_WRITE) begin
        drain_filter();
        write_reg(stim_rows[i].idx, stim_rows[i].data);
        settings_cnt++;
      end else begin
        send_sample(stim_rows[i].smp, stim_rows[i].kind == ROW_CHECKED, stim_rows[i].fexp);
      end
    end

    for (int ph = 0; ph < NPHASE; ph++) begin
      case ((ph == 0) ? 0 : $urandom_range(0, 5))
        0: begin pn = PN_RESET; mn = MN_RESET; end
        1: begin pn = $urandom_range(0, 1 << 20); mn = $urandom_range(1, 1 << 26); end
        2: begin pn = $urandom; mn = $urandom; end
        3: begin pn = 32'd0; mn = $urandom_range(1, 1 << 28); end
        4: begin pn = NOISE_MAX; mn = 32'd1; end
        default: begin pn = $urandom_range(0, 4095); mn = 32'd0; end
      endcase
      drain_filter();
      write_reg(REG_PROC_NOISE, pn);
      write_reg(REG_MEAS_NOISE, mn);
      settings_cnt++;
      case (ph % 3)
        0: idle_pct = 35;
        1: idle_pct = 10;
        default: idle_pct = 0;
      endcase
      if (ph == NPHASE - 1) idle_pct = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) send_sample(next_sample(), 1'b0, '0);
    end

    drain_filter();
    repeat (2 * LATENCY) @(posedge clk_i);

    $display("%0d samples, %0d filtered transfers, %0d noise settings, %0d mismatches",
             samples_sent, results_seen, settings_cnt, mismatches);
    $display("gain held at zero on %0d samples and at unity on %0d", gain_zero_cnt,
             gain_one_cnt);
    if (mismatches == 0 && filtered_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
